@@ rtl/core/asf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the adaptive slider smoothing filter: types, register codes, reset values.
package asf_pkg;

   localparam int SampleW       = 16;
   localparam int ShiftW        = 4;
   localparam int CsrIndexW     = 2;
   localparam int CsrDataW      = 16;

   localparam int FractionBitsDefault = 8;
   localparam int ChannelsDefault     = 2;

   localparam logic [SampleW-1:0] FastThresholdReset = 16'd768;
   localparam logic [ShiftW-1:0]  SlowShiftReset     = 4'd2;
   localparam logic [ShiftW-1:0]  FastShiftReset     = 4'd1;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_FAST_THRESHOLD = 2'd0,
      CSR_SLOW_SHIFT     = 2'd1,
      CSR_FAST_SHIFT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SampleW-1:0] fast_threshold;
      logic [ShiftW-1:0]  slow_shift;
      logic [ShiftW-1:0]  fast_shift;
   } cfg_type;

   typedef struct packed {
      logic               channel;
      logic [SampleW-1:0] raw_sample;
   } req_payload_type;

   typedef struct packed {
      logic               out_channel;
      logic [SampleW-1:0] smoothed_value;
   } rsp_payload_type;

endpackage

@@ rtl/core/asf_csr.sv @@
`timescale 1ns / 1ps
// Configuration registers of the smoothing filter.
module asf_csr
   import asf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FAST_THRESHOLD: cfg_in.fast_threshold = csr_data;
            CSR_SLOW_SHIFT:     cfg_in.slow_shift     = csr_data[ShiftW-1:0];
            CSR_FAST_SHIFT:     cfg_in.fast_shift     = csr_data[ShiftW-1:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_threshold <= FastThresholdReset;
         cfg_ff.slow_shift     <= SlowShiftReset;
         cfg_ff.fast_shift     <= FastShiftReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/asf_step.sv @@
`timescale 1ns / 1ps
// One filter update: first-sample load or adaptive approach of the accumulator, and half-up rounding.
module asf_step
   import asf_pkg::*;
#(
   parameter int FRACTION_BITS = FractionBitsDefault
) (
   input  cfg_type                             cfg,
   input  logic                                primed,
   input  logic [SampleW+FRACTION_BITS-1:0]    acc,
   input  logic [SampleW-1:0]                  raw_sample,
   output logic [SampleW+FRACTION_BITS-1:0]    acc_next,
   output logic [SampleW-1:0]                  smoothed_value
);

   localparam int AccW = SampleW + FRACTION_BITS;
   localparam logic [AccW:0] HalfLsb = (AccW+1)'((64'd1 << FRACTION_BITS) >> 1);

   logic [AccW-1:0]   target;
   logic [AccW-1:0]   limit;
   logic [AccW-1:0]   mag;
   logic [AccW-1:0]   step;
   logic              rising;
   logic [ShiftW-1:0] shift;
   logic [AccW:0]     round_sum;

   assign target = {raw_sample, {FRACTION_BITS{1'b0}}};
   assign limit  = {cfg.fast_threshold, {FRACTION_BITS{1'b0}}};
   assign rising = (target >= acc);
   assign mag    = rising ? (target - acc) : (acc - target);
   // strict compare: a step equal to the threshold stays on the slow shift
   assign shift  = (mag > limit) ? cfg.fast_shift : cfg.slow_shift;
   assign step   = mag >> shift;

   always_comb begin
      if (!primed) begin
         acc_next = target;
      end else if (rising) begin
         acc_next = acc + step;
      end else begin
         acc_next = acc - step;
      end
   end

   assign round_sum      = {1'b0, acc_next} + HalfLsb;
   assign smoothed_value = round_sum[FRACTION_BITS +: SampleW];

endmodule

@@ rtl/core/adaptive_slider_smoothing_filter_top.sv @@
`timescale 1ns / 1ps
// Top level of the adaptive slider smoothing filter.
//
//   port group | direction | handshake          | carries
//   req_       | in        | req_valid/ready    | channel, raw_sample
//   rsp_       | out       | rsp_valid/ready    | out_channel, smoothed_value
//   csr_       | in        | csr_write only     | fast_threshold, slow_shift, fast_shift
//
// A sample is registered on transfer and its result is registered once the result stage is free, so
// one sample can be taken every cycle while the result is not stalled.
// The per-channel state updates in the same edge as the result register, so a following
// sample on the same channel sees the new accumulator with no gap.
// A stalled result holds the result register; the input register still takes one sample.
// Synchronous reset clears the primed flags and pipeline valids, restores the configuration
// registers and holds req_ready low.
module adaptive_slider_smoothing_filter_top
   import asf_pkg::*;
#(
   parameter int FRACTION_BITS = FractionBitsDefault,
   parameter int CHANNELS      = ChannelsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_write,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   localparam int AccW    = SampleW + FRACTION_BITS;
   localparam int ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type          cfg;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   req_payload_type  s1_data_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_data_ff;

   logic [AccW-1:0]  acc_ff    [CHANNELS];
   logic [CHANNELS-1:0] primed_ff;

   logic             advance;
   logic             in_range;
   logic [ChIdxW-1:0] ch_idx;
   logic [AccW-1:0]  acc_next;
   logic [SampleW-1:0] smoothed;

   asf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign in_range = (32'(s1_data_ff.channel) < CHANNELS);
   assign ch_idx   = in_range ? ChIdxW'(s1_data_ff.channel) : '0;

   asf_step #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_step (
      .cfg            (cfg),
      .primed         (primed_ff[ch_idx]),
      .acc            (acc_ff[ch_idx]),
      .raw_sample     (s1_data_ff.raw_sample),
      .acc_next       (acc_next),
      .smoothed_value (smoothed)
   );

   // move the registered sample into the result stage when that stage is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !reset && (!s1_valid_ff || advance);
   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && in_range) begin
            primed_ff[ch_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff.out_channel    <= s1_data_ff.channel;
         rsp_data_ff.smoothed_value <= in_range ? smoothed : '0;
         if (in_range) begin
            acc_ff[ch_idx] <= acc_next;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ tb/adaptive_slider_smoothing_filter_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the slider smoothing filter: directed and random samples, CSR phases.
module adaptive_slider_smoothing_filter_top_tb;
   import asf_pkg::*;

   localparam int FracBits     = FractionBitsDefault;
   localparam int Channels     = ChannelsDefault;
   localparam int AccW         = SampleW + FracBits;
   localparam int QuietLimit   = 2000;
   localparam int PhaseItems   = 140;
   localparam int RandomPhases = 10;
   localparam int CalmPhase    = 5;
   localparam int PausePhase   = 6;
   localparam int IdlePercent  = 33;
   localparam logic [CsrIndexW-1:0] CsrUnused = 2'd3;
   localparam logic [AccW-1:0]      HalfLsb   = AccW'((1 << FracBits) >> 1);

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_data;
   logic                 csr_write = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_data  = '0;

   cfg_type            cfg_model;
   logic [AccW-1:0]    lane_acc [Channels];
   logic               lane_primed [Channels];
   logic [SampleW-1:0] last_sample [Channels];
   req_payload_type    sample_queue [$];
   rsp_payload_type    smoothed_due [$];
   rsp_payload_type    oldest;
   bit                 sender_gaps     = 1'b1;
   bit                 receiver_stalls = 1'b1;
   int                 mismatch_count  = 0;

   adaptive_slider_smoothing_filter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance one channel's estimate and return the rounded position it reports.
   function automatic rsp_payload_type smooth_sample(req_payload_type item);
      logic               ch;
      logic [AccW-1:0]    acc, target, gap, bound, step;
      logic [ShiftW-1:0]  shift;
      rsp_payload_type    r;
      ch     = item.channel;
      acc    = lane_acc[ch];
      target = AccW'(item.raw_sample) << FracBits;
      if (!lane_primed[ch]) begin
         acc             = target;
         lane_primed[ch] = 1'b1;
      end else begin
         gap   = (target >= acc) ? target - acc : acc - target;
         bound = AccW'(cfg_model.fast_threshold) << FracBits;
         // strict compare: a step equal to the threshold stays on the slow path
         shift = (gap > bound) ? cfg_model.fast_shift : cfg_model.slow_shift;
         step  = gap >> shift;
         acc   = (target >= acc) ? acc + step : acc - step;
      end
      lane_acc[ch]     = acc;
      r.out_channel    = ch;
      r.smoothed_value = SampleW'((acc + HalfLsb) >> FracBits);
      return r;
   endfunction

   function automatic logic [SampleW-1:0] clamp_sample(int v);
      if (v < 0)
         return '0;
      if (v > 65535)
         return '1;
      return v[SampleW-1:0];
   endfunction

   task automatic push_sample(logic ch, logic [SampleW-1:0] value);
      req_payload_type item;
      item.channel    = ch;
      item.raw_sample = value;
      sample_queue.push_back(item);
      last_sample[ch] = value;
   endtask

   // Hold until every queued sample is through and every result has come back.
   task automatic settle();
      @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || smoothed_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexW-1:0] index, logic [CsrDataW-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      case (index)
         CSR_FAST_THRESHOLD: cfg_model.fast_threshold = value;
         CSR_SLOW_SHIFT:     cfg_model.slow_shift     = value[ShiftW-1:0];
         CSR_FAST_SHIFT:     cfg_model.fast_shift     = value[ShiftW-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(cfg_type c);
      logic [CsrDataW-1:0] noise;
      settle();
      noise = CsrDataW'($urandom);
      write_csr(CSR_FAST_THRESHOLD, c.fast_threshold);
      // upper data bits are junk for the shift registers
      write_csr(CSR_SLOW_SHIFT, {noise[CsrDataW-1:ShiftW], c.slow_shift});
      write_csr(CSR_FAST_SHIFT, {~noise[CsrDataW-1:ShiftW], c.fast_shift});
      write_csr(CsrUnused, CsrDataW'($urandom));
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Driver: present queued samples, predict each one on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            smoothed_due.push_back(smooth_sample(req_data));
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 &&
                !(sender_gaps && $urandom_range(0, 99) < IdlePercent)) begin
               req_valid <= 1'b1;
               req_data  <= sample_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transfer with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (smoothed_due.size() == 0) begin
               $error("result with nothing pending: out_channel %0d smoothed_value %0d",
                      rsp_data.out_channel, rsp_data.smoothed_value);
               mismatch_count++;
            end else begin
               oldest = smoothed_due.pop_front();
               if (rsp_data.out_channel !== oldest.out_channel) begin
                  $error("out_channel expected %0d actual %0d",
                         oldest.out_channel, rsp_data.out_channel);
                  mismatch_count++;
               end
               if (rsp_data.smoothed_value !== oldest.smoothed_value) begin
                  $error("smoothed_value expected %0d actual %0d",
                         oldest.smoothed_value, rsp_data.smoothed_value);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= !(receiver_stalls && $urandom_range(0, 99) < IdlePercent);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("adaptive_slider_smoothing_filter_top_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      cfg_type plan [RandomPhases];
      int      count, pick, span, offset, value;
      bit      paused;
      logic    ch;

      cfg_model.fast_threshold = FastThresholdReset;
      cfg_model.slow_shift     = SlowShiftReset;
      cfg_model.fast_shift     = FastShiftReset;
      for (int i = 0; i < Channels; i++) begin
         lane_acc[i]    = '0;
         lane_primed[i] = 1'b0;
         last_sample[i] = '0;
      end

      plan[0] = '{16'd0, 4'd0, 4'd0};
      plan[1] = '{16'hFFFF, 4'd15, 4'd15};
      plan[2] = '{16'd0, 4'd15, 4'd0};
      plan[3] = '{16'hFFFF, 4'd0, 4'd15};
      plan[4] = '{FastThresholdReset, SlowShiftReset, FastShiftReset};
      for (int p = 5; p < RandomPhases; p++) begin
         plan[p].fast_threshold = ($urandom_range(0, 3) == 0) ?
                                  16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2000));
         plan[p].slow_shift     = 4'($urandom_range(0, 15));
         plan[p].fast_shift     = 4'($urandom_range(0, 15));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: prime both lanes at the rails, then full-scale and small steps
      push_sample(1'b0, 16'h0000);
      push_sample(1'b1, 16'hFFFF);
      push_sample(1'b0, 16'hFFFF);
      push_sample(1'b1, 16'h0000);
      push_sample(1'b0, 16'hFFFF);
      push_sample(1'b0, 16'hFFFF);
      push_sample(1'b1, 16'h0001);
      push_sample(1'b1, 16'h0002);
      push_sample(1'b0, 16'hAAAA);
      push_sample(1'b1, 16'h5555);

      // zero fast shift lands on target; a step equal to the threshold goes slow
      configure('{16'd100, 4'd15, 4'd0});
      push_sample(1'b0, 16'd5000);
      push_sample(1'b0, 16'd5100);
      push_sample(1'b0, 16'd5201);
      push_sample(1'b0, 16'd5101);
      push_sample(1'b1, 16'd5000);
      push_sample(1'b1, 16'd4900);

      // zero slow shift with zero threshold
      configure('{16'd0, 4'd0, 4'd15});
      push_sample(1'b1, 16'd4900);
      push_sample(1'b1, 16'hFFFF);
      push_sample(1'b0, 16'd0);

      for (int p = 0; p < RandomPhases; p++) begin
         configure(plan[p]);
         sender_gaps     = (p != CalmPhase);
         receiver_stalls = (p != CalmPhase);
         paused = 1'b0;
         count  = 0;
         while (count < PhaseItems) begin
            if (p == PausePhase && !paused && count >= PhaseItems / 2) begin
               settle();
               paused = 1'b1;
            end
            ch   = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 99);
            span = int'(cfg_model.fast_threshold) + 8;
            if (pick < 45) begin
               // jitter around the last sample, on both sides of the threshold
               value = int'(last_sample[ch]) + int'($urandom_range(0, 2 * span)) - span;
               push_sample(ch, clamp_sample(value));
               count++;
            end else if (pick < 65) begin
               push_sample(ch, 16'($urandom_range(0, 65535)));
               count++;
            end else if (pick < 75) begin
               push_sample(ch, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
               count++;
            end else if (pick < 88) begin
               // jump, then step by about the threshold
               value = $urandom_range(0, 65535);
               push_sample(ch, value[SampleW-1:0]);
               offset = int'(cfg_model.fast_threshold) + int'($urandom_range(0, 2)) - 1;
               value  = $urandom_range(0, 1) ? value + offset : value - offset;
               push_sample(ch, clamp_sample(value));
               count += 2;
            end else begin
               push_sample(ch, last_sample[ch]);
               count++;
            end
         end
      end

      settle();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0)
         $display("adaptive_slider_smoothing_filter_top_tb OK");
      else
         $display("adaptive_slider_smoothing_filter_top_tb NOT OK");
      $finish;
   end

endmodule

@@ adaptive_slider_smoothing_filter_top.f @@
rtl/core/asf_pkg.sv
rtl/core/asf_csr.sv
rtl/core/asf_step.sv
rtl/core/adaptive_slider_smoothing_filter_top.sv
tb/adaptive_slider_smoothing_filter_top_tb.sv
